[hw/rtl/rmea_pkg.sv]
`timescale 1ns / 1ps

package rmea_pkg;

    localparam int FRAC_BITS_DEF = 14;
    localparam int ENTRY_W = 16;
    localparam int ANGLE_W = 16;
    localparam int THR_W = 8;
    localparam logic [THR_W-1:0] THR_RESET = 8'd1;
    localparam int ZW = 35;
    localparam int OUT_SHIFT = 17;
    localparam int TAB_LEN = 31;

    localparam longint KINV_Q30 = 64'd652032874;
    localparam longint PI_Q30 = 64'd3373259426;
    localparam longint HALF_PI_Q30 = 64'd1686629713;
    localparam longint WRAP_Q30 = 64'd6746513154;

    localparam logic [31:0] ATAN_TAB [TAB_LEN] = '{
        32'h3243F6A8, 32'h1DAC6705, 32'h0FADBAFC, 32'h07F56EA6, 32'h03FEAB76,
        32'h01FFD55B, 32'h00FFFAAA, 32'h007FFF55, 32'h003FFFEA, 32'h001FFFFD,
        32'h000FFFFF, 32'h0007FFFF, 32'h0003FFFF, 32'h0001FFFF, 32'h0000FFFF,
        32'h00007FFF, 32'h00003FFF, 32'h00001FFF, 32'h00000FFF, 32'h000007FF,
        32'h000003FF, 32'h000001FF, 32'h000000FF, 32'h0000007F, 32'h0000003F,
        32'h0000001F, 32'h0000000F, 32'h00000007, 32'h00000003, 32'h00000001,
        32'h00000000
    };

    function automatic logic [ANGLE_W-1:0] to_angle(input logic signed [ZW-1:0] z);
        logic signed [ZW-1:0] a;
        a = z;
        if (a < 0) begin
            a = a + ZW'(WRAP_Q30);
        end
        if (a < 0) begin
            a = '0;
        end
        return a[OUT_SHIFT +: ANGLE_W];
    endfunction

endpackage

[hw/rtl/rmea_vec.sv]
`timescale 1ns / 1ps

module rmea_vec #(
    parameter int FRAC = rmea_pkg::FRAC_BITS_DEF,
    parameter int DW = 40,
    parameter int SW = 1
) (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            en,
    input  logic                            in_valid,
    input  logic signed [DW-1:0]            in_x,
    input  logic signed [DW-1:0]            in_y,
    input  logic [SW-1:0]                   in_side,
    output logic                            out_valid,
    output logic signed [rmea_pkg::ZW-1:0]  out_z,
    output logic [SW-1:0]                   out_side
);

    localparam int ZW = rmea_pkg::ZW;

    logic                 v_reg    [FRAC+1];
    logic                 zero_reg [FRAC+1];
    logic signed [DW-1:0] x_reg    [FRAC+1];
    logic signed [DW-1:0] y_reg    [FRAC+1];
    logic signed [ZW-1:0] z_reg    [FRAC+1];
    logic [SW-1:0]        side_reg [FRAC+1];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v_reg[0] <= 1'b0;
        end else if (en) begin
            v_reg[0] <= in_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            zero_reg[0] <= (in_x == '0) && (in_y == '0);
            side_reg[0] <= in_side;
            if (in_x < 0) begin
                x_reg[0] <= -in_x;
                y_reg[0] <= -in_y;
                z_reg[0] <= (in_y >= 0) ? ZW'(rmea_pkg::PI_Q30) : -ZW'(rmea_pkg::PI_Q30);
            end else begin
                x_reg[0] <= in_x;
                y_reg[0] <= in_y;
                z_reg[0] <= '0;
            end
        end
    end

    for (genvar i = 0; i < FRAC; i++) begin : g_iter
        always_ff @(posedge aclk) begin
            if (!aresetn) begin
                v_reg[i+1] <= 1'b0;
            end else if (en) begin
                v_reg[i+1] <= v_reg[i];
            end
        end

        always_ff @(posedge aclk) begin
            if (en) begin
                zero_reg[i+1] <= zero_reg[i];
                side_reg[i+1] <= side_reg[i];
                if (y_reg[i] > 0) begin
                    x_reg[i+1] <= x_reg[i] + (y_reg[i] >>> i);
                    y_reg[i+1] <= y_reg[i] - (x_reg[i] >>> i);
                    z_reg[i+1] <= z_reg[i] + ZW'(rmea_pkg::ATAN_TAB[i]);
                end else begin
                    x_reg[i+1] <= x_reg[i] - (y_reg[i] >>> i);
                    y_reg[i+1] <= y_reg[i] + (x_reg[i] >>> i);
                    z_reg[i+1] <= z_reg[i] - ZW'(rmea_pkg::ATAN_TAB[i]);
                end
            end
        end
    end

    assign out_valid = v_reg[FRAC];
    assign out_z = zero_reg[FRAC] ? '0 : z_reg[FRAC];
    assign out_side = side_reg[FRAC];

endmodule

[hw/rtl/rmea_rot.sv]
`timescale 1ns / 1ps

module rmea_rot #(
    parameter int FRAC = rmea_pkg::FRAC_BITS_DEF,
    parameter int SW = 1
) (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            en,
    input  logic                            in_valid,
    input  logic signed [rmea_pkg::ZW-1:0]  in_z,
    input  logic [SW-1:0]                   in_side,
    output logic                            out_valid,
    output logic signed [FRAC+2:0]          out_s,
    output logic signed [FRAC+2:0]          out_c,
    output logic [SW-1:0]                   out_side
);

    localparam int ZW = rmea_pkg::ZW;
    localparam int CW = FRAC + 3;
    localparam longint X0 = (((rmea_pkg::KINV_Q30 << 1) >> (30 - FRAC)) + 1) >> 1;

    logic                 v_reg    [FRAC+1];
    logic                 neg_reg  [FRAC+1];
    logic signed [CW-1:0] x_reg    [FRAC+1];
    logic signed [CW-1:0] y_reg    [FRAC+1];
    logic signed [ZW-1:0] z_reg    [FRAC+1];
    logic [SW-1:0]        side_reg [FRAC+1];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v_reg[0] <= 1'b0;
        end else if (en) begin
            v_reg[0] <= in_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            side_reg[0] <= in_side;
            x_reg[0] <= CW'(X0);
            y_reg[0] <= '0;
            if (in_z > ZW'(rmea_pkg::HALF_PI_Q30)) begin
                z_reg[0] <= in_z - ZW'(rmea_pkg::PI_Q30);
                neg_reg[0] <= 1'b1;
            end else if (in_z < -ZW'(rmea_pkg::HALF_PI_Q30)) begin
                z_reg[0] <= in_z + ZW'(rmea_pkg::PI_Q30);
                neg_reg[0] <= 1'b1;
            end else begin
                z_reg[0] <= in_z;
                neg_reg[0] <= 1'b0;
            end
        end
    end

    for (genvar i = 0; i < FRAC; i++) begin : g_iter
        always_ff @(posedge aclk) begin
            if (!aresetn) begin
                v_reg[i+1] <= 1'b0;
            end else if (en) begin
                v_reg[i+1] <= v_reg[i];
            end
        end

        always_ff @(posedge aclk) begin
            if (en) begin
                neg_reg[i+1] <= neg_reg[i];
                side_reg[i+1] <= side_reg[i];
                if (z_reg[i] >= 0) begin
                    x_reg[i+1] <= x_reg[i] - (y_reg[i] >>> i);
                    y_reg[i+1] <= y_reg[i] + (x_reg[i] >>> i);
                    z_reg[i+1] <= z_reg[i] - ZW'(rmea_pkg::ATAN_TAB[i]);
                end else begin
                    x_reg[i+1] <= x_reg[i] + (y_reg[i] >>> i);
                    y_reg[i+1] <= y_reg[i] - (x_reg[i] >>> i);
                    z_reg[i+1] <= z_reg[i] + ZW'(rmea_pkg::ATAN_TAB[i]);
                end
            end
        end
    end

    assign out_valid = v_reg[FRAC];
    assign out_c = neg_reg[FRAC] ? -x_reg[FRAC] : x_reg[FRAC];
    assign out_s = neg_reg[FRAC] ? -y_reg[FRAC] : y_reg[FRAC];
    assign out_side = side_reg[FRAC];

endmodule

[hw/rtl/rotation_matrix_to_euler_angles_core.sv]
`timescale 1ns / 1ps
// Throughput is one matrix per cycle when the output is not stalled. Stages: input
// register, yaw and sin/cos CORDIC, products, operands, roll/pitch CORDIC, output.
// A stall on the output side holds the whole pipeline in place.
// Reset is synchronous and active low; it clears all valid bits and sets the
// gimbal threshold to 1.
module rotation_matrix_to_euler_angles_core #(
    parameter int FRAC_BITS = rmea_pkg::FRAC_BITS_DEF
) (
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         cfg_wr_en,
    input  logic [7:0]   cfg_wr_data,
    input  logic         s_axis_tvalid,
    output logic         s_axis_tready,
    // m11, m12, m13, m21, m22, m23, m31 from the lowest bit up.
    input  logic [111:0] s_axis_tdata,
    output logic         m_axis_tvalid,
    input  logic         m_axis_tready,
    // yaw_angle, roll_angle, pitch_angle from the lowest bit up.
    output logic [47:0]  m_axis_tdata,
    // gimbal_lock.
    output logic [0:0]   m_axis_tuser
);

    localparam int EW = rmea_pkg::ENTRY_W;
    localparam int AW = rmea_pkg::ANGLE_W;
    localparam int ZW = rmea_pkg::ZW;
    localparam int DW = FRAC_BITS + 22;
    localparam int CW = FRAC_BITS + 3;
    localparam int PW = CW + EW;
    localparam int MW = 7 * EW;

    logic en;
    logic [rmea_pkg::THR_W-1:0] thr_reg;

    logic                 in_valid_reg;
    logic [MW-1:0]        m_reg;
    logic                 lock_reg;
    logic signed [EW:0]   m11_in;
    logic signed [EW:0]   m21_in;

    logic                 yaw_valid;
    logic signed [ZW-1:0] yaw_z;
    logic [MW:0]          yaw_side;

    logic                 rot_valid;
    logic signed [CW-1:0] rot_s;
    logic signed [CW-1:0] rot_c;
    logic [AW+MW:0]       rot_side;
    logic signed [EW-1:0] r_m11, r_m12, r_m13, r_m21, r_m22, r_m23, r_m31;

    logic                 p_valid_reg;
    logic signed [PW-1:0] p1_reg, p2_reg, p3_reg, p4_reg, p5_reg, p6_reg;
    logic signed [EW-1:0] p_m11_reg, p_m22_reg, p_m23_reg, p_m31_reg;
    logic [AW-1:0]        p_yaw_reg;
    logic                 p_lock_reg;

    logic                 o_valid_reg;
    logic signed [DW-1:0] roll_x_reg, roll_y_reg, pitch_x_reg, pitch_y_reg;
    logic [AW-1:0]        o_yaw_reg;
    logic                 o_lock_reg;

    logic                 roll_valid, pitch_valid;
    logic signed [ZW-1:0] roll_z, pitch_z;
    logic [AW-1:0]        roll_side;
    logic [0:0]           pitch_side;

    logic                 out_valid_reg;
    logic [47:0]          out_data_reg;
    logic                 out_lock_reg;

    assign en = !out_valid_reg || m_axis_tready;
    assign s_axis_tready = en;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            thr_reg <= rmea_pkg::THR_RESET;
        end else if (cfg_wr_en) begin
            thr_reg <= cfg_wr_data;
        end
    end

    assign m11_in = (EW+1)'($signed(s_axis_tdata[0*EW +: EW]));
    assign m21_in = (EW+1)'($signed(s_axis_tdata[3*EW +: EW]));

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (en) begin
            in_valid_reg <= s_axis_tvalid;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            m_reg <= s_axis_tdata;
            lock_reg <= ((m11_in < 0 ? -m11_in : m11_in) < $signed({1'b0, 8'(0), thr_reg}))
                     && ((m21_in < 0 ? -m21_in : m21_in) < $signed({1'b0, 8'(0), thr_reg}));
        end
    end

    rmea_vec #(.FRAC(FRAC_BITS), .DW(DW), .SW(MW + 1)) u_yaw (
        .aclk(aclk), .aresetn(aresetn), .en(en),
        .in_valid(in_valid_reg),
        .in_x(DW'($signed(m_reg[0*EW +: EW])) <<< FRAC_BITS),
        .in_y(DW'($signed(m_reg[3*EW +: EW])) <<< FRAC_BITS),
        .in_side({lock_reg, m_reg}),
        .out_valid(yaw_valid), .out_z(yaw_z), .out_side(yaw_side)
    );

    rmea_rot #(.FRAC(FRAC_BITS), .SW(AW + MW + 1)) u_sincos (
        .aclk(aclk), .aresetn(aresetn), .en(en),
        .in_valid(yaw_valid),
        .in_z(yaw_z),
        .in_side({rmea_pkg::to_angle(yaw_z), yaw_side}),
        .out_valid(rot_valid), .out_s(rot_s), .out_c(rot_c), .out_side(rot_side)
    );

    assign r_m11 = $signed(rot_side[0*EW +: EW]);
    assign r_m12 = $signed(rot_side[1*EW +: EW]);
    assign r_m13 = $signed(rot_side[2*EW +: EW]);
    assign r_m21 = $signed(rot_side[3*EW +: EW]);
    assign r_m22 = $signed(rot_side[4*EW +: EW]);
    assign r_m23 = $signed(rot_side[5*EW +: EW]);
    assign r_m31 = $signed(rot_side[6*EW +: EW]);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            p_valid_reg <= 1'b0;
        end else if (en) begin
            p_valid_reg <= rot_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            p1_reg <= PW'(rot_s) * PW'(r_m13);
            p2_reg <= PW'(rot_c) * PW'(r_m23);
            p3_reg <= PW'(rot_c) * PW'(r_m22);
            p4_reg <= PW'(rot_s) * PW'(r_m12);
            p5_reg <= PW'(rot_c) * PW'(r_m11);
            p6_reg <= PW'(rot_s) * PW'(r_m21);
            p_m11_reg <= r_m11;
            p_m22_reg <= r_m22;
            p_m23_reg <= r_m23;
            p_m31_reg <= r_m31;
            p_lock_reg <= rot_side[MW];
            p_yaw_reg <= rot_side[MW+1 +: AW];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            o_valid_reg <= 1'b0;
        end else if (en) begin
            o_valid_reg <= p_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            o_yaw_reg <= p_yaw_reg;
            o_lock_reg <= p_lock_reg;
            pitch_y_reg <= -(DW'(p_m31_reg) <<< FRAC_BITS);
            if (p_lock_reg) begin
                roll_y_reg <= -(DW'(p_m23_reg) <<< FRAC_BITS);
                roll_x_reg <= DW'(p_m22_reg) <<< FRAC_BITS;
                pitch_x_reg <= DW'(p_m11_reg) <<< FRAC_BITS;
            end else begin
                roll_y_reg <= DW'(p1_reg) - DW'(p2_reg);
                roll_x_reg <= DW'(p3_reg) - DW'(p4_reg);
                pitch_x_reg <= DW'(p5_reg) + DW'(p6_reg);
            end
        end
    end

    rmea_vec #(.FRAC(FRAC_BITS), .DW(DW), .SW(AW)) u_roll (
        .aclk(aclk), .aresetn(aresetn), .en(en),
        .in_valid(o_valid_reg), .in_x(roll_x_reg), .in_y(roll_y_reg),
        .in_side(o_yaw_reg),
        .out_valid(roll_valid), .out_z(roll_z), .out_side(roll_side)
    );

    rmea_vec #(.FRAC(FRAC_BITS), .DW(DW), .SW(1)) u_pitch (
        .aclk(aclk), .aresetn(aresetn), .en(en),
        .in_valid(o_valid_reg), .in_x(pitch_x_reg), .in_y(pitch_y_reg),
        .in_side(o_lock_reg),
        .out_valid(pitch_valid), .out_z(pitch_z), .out_side(pitch_side)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (en) begin
            out_valid_reg <= roll_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            out_data_reg <= {rmea_pkg::to_angle(pitch_z), rmea_pkg::to_angle(roll_z),
                             pitch_side[0] ? AW'(0) : roll_side};
            out_lock_reg <= pitch_side[0];
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata = out_data_reg;
    assign m_axis_tuser = out_lock_reg;

    a_lanes_aligned: assert property (@(posedge aclk) disable iff (!aresetn)
        roll_valid == pitch_valid)
        else $error("roll and pitch pipelines out of step");

    a_lock_yaw_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_axis_tvalid && m_axis_tuser[0] |-> m_axis_tdata[15:0] == 16'd0)
        else $error("yaw not zero under gimbal lock");

    a_ready_rule: assert property (@(posedge aclk) disable iff (!aresetn)
        s_axis_tready == (!m_axis_tvalid || m_axis_tready))
        else $error("input ready does not follow output stall");

endmodule

[verif/tb.sv]
`timescale 1ns / 1ps

module tb;

    typedef struct packed {
        logic [15:0] yaw;
        logic [15:0] roll;
        logic [15:0] pitch;
        logic        lock;
    } angles_t;

    logic         aclk = 1'b0;
    logic         aresetn = 1'b0;
    logic         cfg_wr_en = 1'b0;
    logic [7:0]   cfg_wr_data = '0;
    logic         s_axis_tvalid = 1'b0;
    logic         s_axis_tready;
    logic [111:0] s_axis_tdata = '0;
    logic         m_axis_tvalid;
    logic         m_axis_tready = 1'b0;
    logic [47:0]  m_axis_tdata;
    logic [0:0]   m_axis_tuser;

    angles_t angle_queue[$];
    int errors = 0;
    int words_sent = 0;
    int results_seen = 0;
    int idle_cycles = 0;
    int send_idle_pct = 0;
    int recv_stall_pct = 0;
    int hold_off = 0;
    logic [7:0] threshold = rmea_pkg::THR_RESET;
    localparam int LATENCY = 3 * rmea_pkg::FRAC_BITS_DEF + 7;
    localparam int WATCHDOG = 20000;

    rotation_matrix_to_euler_angles_core dut (.*);

    always #2 aclk = ~aclk;

    function automatic longint shr(longint v, int s);
        return v >>> s;
    endfunction

    function automatic longint vec_atan2(longint y, longint x);
        longint z, dx, dy;
        z = 0;
        if (x == 0 && y == 0) return 0;
        if (x < 0) begin
            z = (y >= 0) ? rmea_pkg::PI_Q30 : -rmea_pkg::PI_Q30;
            x = -x;
            y = -y;
        end
        for (int i = 0; i < rmea_pkg::FRAC_BITS_DEF; i++) begin
            dx = shr(y, i);
            dy = shr(x, i);
            if (y > 0) begin
                x += dx; y -= dy; z += longint'(rmea_pkg::ATAN_TAB[i]);
            end else begin
                x -= dx; y += dy; z -= longint'(rmea_pkg::ATAN_TAB[i]);
            end
        end
        return z;
    endfunction

    task automatic rot_sincos(input longint zin, output longint s, output longint c);
        longint z, x, y, dx, dy;
        bit neg;
        z = zin;
        neg = 0;
        if (z > rmea_pkg::HALF_PI_Q30) begin
            z -= rmea_pkg::PI_Q30; neg = 1;
        end else if (z < -rmea_pkg::HALF_PI_Q30) begin
            z += rmea_pkg::PI_Q30; neg = 1;
        end
        x = (((rmea_pkg::KINV_Q30 << 1) >> (30 - rmea_pkg::FRAC_BITS_DEF)) + 1) >> 1;
        y = 0;
        for (int i = 0; i < rmea_pkg::FRAC_BITS_DEF; i++) begin
            dx = shr(y, i);
            dy = shr(x, i);
            if (z >= 0) begin
                x -= dx; y += dy; z -= longint'(rmea_pkg::ATAN_TAB[i]);
            end else begin
                x += dx; y -= dy; z += longint'(rmea_pkg::ATAN_TAB[i]);
            end
        end
        c = neg ? -x : x;
        s = neg ? -y : y;
    endtask

    function automatic logic [15:0] wrap_angle(longint a);
        if (a < 0) a += rmea_pkg::WRAP_Q30;
        if (a < 0) a = 0;
        return 16'(a >> rmea_pkg::OUT_SHIFT);
    endfunction

    task automatic predict_angles(input logic [111:0] d, output angles_t r);
        longint m[7];
        longint one, yaw, roll, pitch, s, c;
        bit lock;
        for (int k = 0; k < 7; k++) m[k] = longint'($signed(d[16*k +: 16]));
        one = longint'(1) << rmea_pkg::FRAC_BITS_DEF;
        lock = (m[0] < 0 ? -m[0] : m[0]) < threshold && (m[3] < 0 ? -m[3] : m[3]) < threshold;
        if (lock) begin
            yaw = 0;
            roll = vec_atan2(-m[5] * one, m[4] * one);
            pitch = vec_atan2(-m[6] * one, m[0] * one);
        end else begin
            yaw = vec_atan2(m[3] * one, m[0] * one);
            rot_sincos(yaw, s, c);
            roll = vec_atan2(s * m[2] - c * m[5], c * m[4] - s * m[1]);
            pitch = vec_atan2(-m[6] * one, c * m[0] + s * m[3]);
        end
        r.yaw = wrap_angle(yaw);
        r.roll = wrap_angle(roll);
        r.pitch = wrap_angle(pitch);
        r.lock = lock;
    endtask

    task automatic send_matrix(input logic [111:0] d);
        angles_t r;
        while (send_idle_pct > 0 && $urandom_range(99) < send_idle_pct) begin
            s_axis_tvalid <= 1'b0;
            @(posedge aclk);
        end
        predict_angles(d, r);
        angle_queue.push_back(r);
        s_axis_tdata <= d;
        s_axis_tvalid <= 1'b1;
        do @(posedge aclk); while (!s_axis_tready);
        words_sent++;
    endtask

    task automatic drain;
        s_axis_tvalid <= 1'b0;
        while (angle_queue.size() > 0) @(posedge aclk);
        repeat (LATENCY + 10) @(posedge aclk);
    endtask

    task automatic write_threshold(input logic [7:0] v);
        drain();
        cfg_wr_data <= v;
        cfg_wr_en <= 1'b1;
        @(posedge aclk);
        cfg_wr_en <= 1'b0;
        threshold = v;
    endtask

    function automatic logic [15:0] rand_entry();
        case ($urandom_range(9))
            0: return 16'($urandom);
            1: return 16'(-16384);
            2: return 16'(16384);
            3: return 16'($signed($urandom_range(8)) - 4);
            default: return 16'($signed($urandom_range(32768)) - 16384);
        endcase
    endfunction

    function automatic logic [111:0] rand_matrix();
        logic [111:0] d;
        for (int k = 0; k < 7; k++) d[16*k +: 16] = rand_entry();
        if ($urandom_range(4) == 0) begin
            d[15:0] = 16'($signed($urandom_range(2 * threshold + 2)) - threshold - 1);
            d[63:48] = 16'($signed($urandom_range(2 * threshold + 2)) - threshold - 1);
        end
        return d;
    endfunction

    task automatic test_directed;
        logic [15:0] v[6] = '{16'h0000, 16'h4000, 16'hC000, 16'h7FFF, 16'h8000, 16'hFFFF};
        for (int i = 0; i < 6; i++)
            send_matrix({7{v[i]}});
        send_matrix({16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'h4000});
        send_matrix({16'h0000, 16'h4000, 16'h0000, 16'h0000, 16'h0000, 16'h4000, 16'h4000});
        send_matrix({16'h0000, 16'hC000, 16'h0000, 16'h0000, 16'h4000, 16'h0000, 16'h0000});
        send_matrix({16'h4000, 16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'h0000});
        send_matrix({16'h0000, 16'h0000, 16'h4000, 16'h0000, 16'h4000, 16'h0000, 16'h0000});
        send_matrix({16'h1234, 16'hEDCB, 16'h4000, 16'hFFFF, 16'h0001, 16'h2000, 16'h0000});
        send_matrix({16'hC000, 16'h0000, 16'h0000, 16'h0001, 16'h0000, 16'h0000, 16'hC000});
        send_matrix({16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'h8000});
    endtask

    task automatic test_thresholds;
        logic [7:0] t[4] = '{8'd0, 8'd255, 8'd16, 8'd1};
        for (int i = 0; i < 4; i++) begin
            write_threshold(t[i]);
            repeat (40) send_matrix(rand_matrix());
        end
    endtask

    task automatic test_idle_phases;
        int s_pct[4] = '{0, 50, 0, 31};
        int r_pct[4] = '{0, 0, 50, 31};
        for (int p = 0; p < 4; p++) begin
            send_idle_pct = s_pct[p];
            recv_stall_pct = r_pct[p];
            repeat (200) send_matrix(rand_matrix());
        end
        send_idle_pct = 0;
        recv_stall_pct = 0;
    endtask

    task automatic test_backpressure;
        hold_off = 300;
        repeat (120) send_matrix(rand_matrix());
        drain();
        write_threshold(8'd4);
        repeat (50) send_matrix(rand_matrix());
    endtask

    always @(posedge aclk) begin
        if (hold_off > 0) begin
            hold_off <= hold_off - 1;
            m_axis_tready <= 1'b0;
        end else begin
            m_axis_tready <= aresetn && ($urandom_range(99) >= recv_stall_pct);
        end
    end

    always @(posedge aclk) begin
        angles_t exp_r, got;
        if (aresetn && m_axis_tvalid && m_axis_tready) begin
            got = {m_axis_tdata[15:0], m_axis_tdata[31:16], m_axis_tdata[47:32], m_axis_tuser[0]};
            results_seen++;
            if (angle_queue.size() == 0) begin
                errors++;
                $display("%0t: unexpected word %h", $time, got);
            end else begin
                exp_r = angle_queue.pop_front();
                if (got !== exp_r) begin
                    errors++;
                    $display("%0t: mismatch expected yaw %0d roll %0d pitch %0d lock %0b",
                             $time, exp_r.yaw, exp_r.roll, exp_r.pitch, exp_r.lock);
                    $display("%0t:          actual   yaw %0d roll %0d pitch %0d lock %0b",
                             $time, got.yaw, got.roll, got.pitch, got.lock);
                end
            end
        end
    end

    always @(posedge aclk) begin
        if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles > WATCHDOG) begin
            $display("rotation_matrix_to_euler_angles_core verification failed");
            $finish;
        end
    end

    initial begin
        repeat (8) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);
        test_directed();
        test_thresholds();
        test_idle_phases();
        test_backpressure();
        drain();
        if (angle_queue.size() > 0) begin
            errors++;
            $display("%0t: %0d expected words never arrived", $time, angle_queue.size());
        end
        $display("Sent %0d matrices and checked %0d angle words", words_sent, results_seen);
        $display("over five gimbal thresholds, four idle patterns and a long output stall.");
        if (errors == 0)
            $display("rotation_matrix_to_euler_angles_core verification clean");
        else
            $display("rotation_matrix_to_euler_angles_core verification failed");
        $finish;
    end
endmodule
